[hdl/npstr_pkg.sv]
// Shared types and constants for the next-permutation word block.
package npstr_pkg;

   localparam int LETTER_W = 5;
   localparam int STATUS_W = 2;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      RSP_LETTER = 2'd0,
      RSP_NONE   = 2'd1,
      RSP_LONG   = 2'd2
   } rsp_status_type;

   // Source of memory write data during the swap and reverse walks
   typedef enum logic [1:0] {
      WR_RD  = 2'd0,
      WR_PIV = 2'd1,
      WR_TMP = 2'd2
   } wr_src_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LONG,
      S_NONE,
      S_PV_RD0,
      S_PV_FIRST,
      S_PV_RD,
      S_PV_CMP,
      S_SC_RD,
      S_SC_CMP,
      S_SW2,
      S_RV_CHK,
      S_RV_RDL,
      S_RV_RDH,
      S_RV_WL,
      S_RV_WH,
      S_EM_RD,
      S_EM_OUT
   } npstr_state_type;

   // Controller to datapath
   typedef struct packed {
      logic           load;       // accepted letter beat
      logic           a_init;     // a <= index of the incoming letter
      logic           a_end;      // a <= length - 1
      logic           a_dec;
      logic           a_inc;
      logic           a_clr;
      logic           b_take;     // pivot found: b <= a, piv <= rd
      logic           b_inc;
      logic           prev_load;
      logic           tmp_load;
      logic           rd_en;
      logic           rd_sel_b;
      logic           we;
      logic           wr_sel_b;
      wr_src_type     wr_src;
      logic           emit;
      rsp_status_type emit_status;
      logic           emit_last;
      logic           clear;      // word done: length and overflow back to zero
   } npstr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic too_long;
      logic a_zero;
      logic rd_lt_prev;
      logic rd_gt_piv;
      logic b_lt_a;
      logic a_at_end;
   } npstr_sts_type;

endpackage

[hdl/npstr_dpath.sv]
// Datapath: word store, walk pointers, holding registers and result registers.
module npstr_dpath
   import npstr_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  npstr_cmd_type       cmd,
   input  logic [LETTER_W-1:0] req_letter,
   output npstr_sts_type       sts,
   output logic                rsp_strobe,
   output logic [LETTER_W-1:0] rsp_out_letter,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_out_last
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = $clog2(MAX_LEN);

   logic [LETTER_W-1:0] mem [MAX_LEN];

   logic [LEN_W-1:0]    len_ff, len_in;
   logic                ovf_ff, ovf_in;
   logic [IDX_W-1:0]    a_ff, a_in;
   logic [IDX_W-1:0]    b_ff, b_in;
   logic [LETTER_W-1:0] rd_ff, piv_ff, prev_ff, tmp_ff;
   logic                strobe_ff;
   logic [LETTER_W-1:0] out_letter_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                out_last_ff;

   logic                full;
   logic [LEN_W-1:0]    len_m1;
   logic [IDX_W-1:0]    len_idx, end_idx;
   logic                we;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   logic [LETTER_W-1:0] wr_data;

   assign full    = (len_ff == LEN_W'(MAX_LEN));
   assign len_m1  = len_ff - LEN_W'(1);
   assign len_idx = len_ff[IDX_W-1:0];
   assign end_idx = len_m1[IDX_W-1:0];

   // single write port shared by loading and the swap / reverse walks
   always_comb begin
      we      = (cmd.load && !full) || cmd.we;
      wr_addr = cmd.load ? len_idx : (cmd.wr_sel_b ? b_ff : a_ff);
      case (cmd.wr_src)
         WR_RD:   wr_data = rd_ff;
         WR_PIV:  wr_data = piv_ff;
         WR_TMP:  wr_data = tmp_ff;
         default: wr_data = rd_ff;
      endcase
      if (cmd.load) begin
         wr_data = req_letter;
      end
      rd_addr = cmd.rd_sel_b ? b_ff : a_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (cmd.clear) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
         end
      end

      a_in = a_ff;
      if (cmd.a_init) begin
         a_in = len_idx;
      end else if (cmd.a_end) begin
         a_in = end_idx;
      end else if (cmd.a_dec) begin
         a_in = a_ff - IDX_W'(1);
      end else if (cmd.a_inc) begin
         a_in = a_ff + IDX_W'(1);
      end else if (cmd.a_clr) begin
         a_in = '0;
      end

      b_in = b_ff;
      if (cmd.b_take) begin
         b_in = a_ff;
      end else if (cmd.b_inc) begin
         b_in = b_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      if (cmd.b_take) begin
         piv_ff <= rd_ff;
      end
      if (cmd.prev_load) begin
         prev_ff <= rd_ff;
      end
      if (cmd.tmp_load) begin
         tmp_ff <= rd_ff;
      end
      if (cmd.emit) begin
         out_letter_ff <= (cmd.emit_status == RSP_LETTER) ? rd_ff : '0;
         status_ff     <= cmd.emit_status;
         out_last_ff   <= cmd.emit_last;
      end
   end

   always_comb begin
      sts.too_long   = ovf_ff || full;
      sts.a_zero     = (a_ff == '0);
      sts.rd_lt_prev = (rd_ff < prev_ff);
      sts.rd_gt_piv  = (rd_ff > piv_ff);
      sts.b_lt_a     = (b_ff < a_ff);
      sts.a_at_end   = (a_ff == end_idx);
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_out_letter = out_letter_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_last   = out_last_ff;

endmodule

[hdl/npstr_ctrl.sv]
// Controller: sequences load, pivot scan, successor scan, swap, reverse and emit.
module npstr_ctrl
   import npstr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_last,
   input  npstr_sts_type sts,
   output logic          busy,
   output npstr_cmd_type cmd
);

   npstr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.wr_src      = WR_RD;
      cmd.emit_status = RSP_LETTER;
      busy            = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  if (sts.too_long) begin
                     state_in = S_LONG;
                  end else begin
                     cmd.a_init = 1'b1;
                     state_in   = S_PV_RD0;
                  end
               end
            end
         end
         S_LONG: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = RSP_LONG;
            cmd.emit_last   = 1'b1;
            cmd.clear       = 1'b1;
            state_in        = S_IDLE;
         end
         S_NONE: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = RSP_NONE;
            cmd.emit_last   = 1'b1;
            cmd.clear       = 1'b1;
            state_in        = S_IDLE;
         end
         // pivot scan, right to left
         S_PV_RD0: begin
            cmd.rd_en = 1'b1;
            state_in  = S_PV_FIRST;
         end
         S_PV_FIRST: begin
            cmd.prev_load = 1'b1;
            if (sts.a_zero) begin
               state_in = S_NONE;
            end else begin
               cmd.a_dec = 1'b1;
               state_in  = S_PV_RD;
            end
         end
         S_PV_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_PV_CMP;
         end
         S_PV_CMP: begin
            if (sts.rd_lt_prev) begin
               cmd.b_take = 1'b1;
               cmd.a_end  = 1'b1;
               state_in   = S_SC_RD;
            end else begin
               cmd.prev_load = 1'b1;
               if (sts.a_zero) begin
                  state_in = S_NONE;
               end else begin
                  cmd.a_dec = 1'b1;
                  state_in  = S_PV_RD;
               end
            end
         end
         // rightmost letter above the pivot
         S_SC_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SC_CMP;
         end
         S_SC_CMP: begin
            if (sts.rd_gt_piv) begin
               cmd.we       = 1'b1;
               cmd.wr_sel_b = 1'b1;
               cmd.wr_src   = WR_RD;
               state_in     = S_SW2;
            end else begin
               cmd.a_dec = 1'b1;
               state_in  = S_SC_RD;
            end
         end
         S_SW2: begin
            cmd.we     = 1'b1;
            cmd.wr_src = WR_PIV;
            cmd.b_inc  = 1'b1;
            cmd.a_end  = 1'b1;
            state_in   = S_RV_CHK;
         end
         // suffix reversal
         S_RV_CHK: begin
            if (sts.b_lt_a) begin
               state_in = S_RV_RDL;
            end else begin
               cmd.a_clr = 1'b1;
               state_in  = S_EM_RD;
            end
         end
         S_RV_RDL: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel_b = 1'b1;
            state_in     = S_RV_RDH;
         end
         S_RV_RDH: begin
            cmd.tmp_load = 1'b1;
            cmd.rd_en    = 1'b1;
            state_in     = S_RV_WL;
         end
         S_RV_WL: begin
            cmd.we       = 1'b1;
            cmd.wr_sel_b = 1'b1;
            cmd.wr_src   = WR_RD;
            state_in     = S_RV_WH;
         end
         S_RV_WH: begin
            cmd.we     = 1'b1;
            cmd.wr_src = WR_TMP;
            cmd.b_inc  = 1'b1;
            cmd.a_dec  = 1'b1;
            state_in   = S_RV_CHK;
         end
         // emit: read in S_EM_RD, present in S_EM_OUT
         S_EM_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EM_OUT;
         end
         S_EM_OUT: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = RSP_LETTER;
            cmd.emit_last   = sts.a_at_end;
            if (sts.a_at_end) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cmd.a_inc = 1'b1;
               state_in  = S_EM_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/next_permutation_string.sv]
// Top level: next lexicographic permutation of a word of letters.
//
//  channel  ports                                       beat taken when
//  -------  ------------------------------------------  ---------------------------
//  request  start, busy, req_letter, req_last           start && !busy at clock edge
//  result   rsp_strobe, rsp_out_letter, rsp_status,     rsp_strobe high (one cycle,
//           rsp_out_last                                receiver cannot stall)
//
// Letter beats load one per cycle into the word store while busy is low.
// The beat carrying req_last starts the end-of-word walks; busy stays high
// until the last result has been issued. All walks share the store's single
// read port and single write port, with registered read data, and run in
// order: pivot scan, successor scan, swap, suffix reversal, emission. An
// over-long or already-last word gives a single result instead. Results
// leave from registers in the cycle after the controller issues them.
// Reset (synchronous, active high) clears the controller, length, overflow
// flag and result strobe; the word store needs no clearing pass.
module next_permutation_string
   import npstr_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last,
   output logic                rsp_strobe,
   output logic [LETTER_W-1:0] rsp_out_letter,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_out_last
);

   npstr_cmd_type cmd;
   npstr_sts_type sts;

   // sequencer for the load and the end-of-word walks
   npstr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   // word store, pointers and result registers
   npstr_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_letter     (req_letter),
      .sts            (sts),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_letter (rsp_out_letter),
      .rsp_status     (rsp_status),
      .rsp_out_last   (rsp_out_last)
   );

endmodule

[test/tb_top.sv]
// Testbench for next_permutation_string: directed words, then random words against a predictor.
`timescale 1ns / 100ps

module tb_top
   import npstr_pkg::*;
();

   localparam int WORD_MAX     = 64;   // longest word the block stores
   localparam int RANDOM_BEATS = 116;  // letter beats in the random part, at the least
   localparam int DRAIN_CYCLES = 800;  // idle wait after the last awaited result

   // One result beat as it leaves the block
   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      rsp_status_type      status;
      logic                last;
   } perm_beat_type;

   // One row of the directed table: a run of identical letter beats.
   // The last flag and any typed-in expectation apply to the final beat of the run.
   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic [6:0]          reps;
      logic                last;
      logic                typed;
      rsp_status_type      status;
   } word_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [LETTER_W-1:0] req_letter = '0;
   logic                req_last = 1'b0;
   logic                rsp_strobe;
   logic [LETTER_W-1:0] rsp_out_letter;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_out_last;

   // Predictor's own copy of the word being loaded
   logic [LETTER_W-1:0] word_buf [WORD_MAX];
   int                  word_len = 0;
   bit                  word_overflow = 1'b0;

   perm_beat_type       fresh_results [$];   // results caused by the latest letter beat
   perm_beat_type       awaited_results [$]; // results still due from the block
   word_row_type        word_table [$];

   int                  error_count = 0;
   int                  beats_sent = 0;
   bit                  quiet = 1'b0;        // no sender idling while set

   always #5 clock = ~clock;

   next_permutation_string #(
      .MAX_LEN(WORD_MAX)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_letter    (req_letter),
      .req_last      (req_last),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_letter(rsp_out_letter),
      .rsp_status    (rsp_status),
      .rsp_out_last  (rsp_out_last)
   );

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void push_fresh(input logic [LETTER_W-1:0] letter,
                                      input rsp_status_type status, input logic last);
      perm_beat_type r;
      r.letter = letter;
      r.status = status;
      r.last   = last;
      fresh_results.push_back(r);
   endfunction

   // Next-permutation predictor: stores each letter, and on the final beat works out
   // the next lexicographic arrangement (or the no-answer / too-long outcome).
   function automatic void absorb_letter(input logic [LETTER_W-1:0] letter, input logic last);
      int               n;
      int               i;
      int               pivot;
      int               succ;
      int               lo;
      int               hi;
      bit               found;
      logic [LETTER_W-1:0] t;
      fresh_results.delete();
      if (word_len < WORD_MAX) begin
         word_buf[word_len] = letter;
         word_len++;
      end else begin
         word_overflow = 1'b1;
      end
      if (!last) return;

      if (word_overflow) begin
         push_fresh('0, RSP_LONG, 1'b1);
      end else begin
         n     = word_len;
         found = 1'b0;
         pivot = 0;
         // rightmost letter smaller than its right-hand neighbour
         for (i = n - 1; i > 0 && !found; i--) begin
            if (word_buf[i-1] < word_buf[i]) begin
               pivot = i - 1;
               found = 1'b1;
            end
         end
         if (!found) begin
            push_fresh('0, RSP_NONE, 1'b1);
         end else begin
            // suffix is non-increasing, so the rightmost larger letter is the smallest one
            succ = n - 1;
            while (word_buf[succ] <= word_buf[pivot]) succ--;
            t               = word_buf[pivot];
            word_buf[pivot] = word_buf[succ];
            word_buf[succ]  = t;
            lo = pivot + 1;
            hi = n - 1;
            while (lo < hi) begin
               t            = word_buf[lo];
               word_buf[lo] = word_buf[hi];
               word_buf[hi] = t;
               lo++;
               hi--;
            end
            for (i = 0; i < n; i++) push_fresh(word_buf[i], RSP_LETTER, i == n - 1);
         end
      end
      // word done: ready for the next one
      word_len      = 0;
      word_overflow = 1'b0;
   endfunction

   // Drive one letter beat, wait for it to be taken, queue its results, then idle at random.
   // start stays high from beat to beat unless an idle cycle is drawn, so it is never
   // lowered and raised in the same step.
   task automatic send_beat(input logic [LETTER_W-1:0] letter, input logic last,
                            input logic typed, input rsp_status_type status);
      perm_beat_type r;
      req_letter <= letter;
      req_last   <= last;
      start      <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      absorb_letter(letter, last);
      if (typed) begin
         // typed-in expectation stands in for the predictor on this beat
         r.letter = '0;
         r.status = status;
         r.last   = 1'b1;
         awaited_results.push_back(r);
      end else begin
         foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
      end
      beats_sent++;
      // sender idling: noise on the letter fields while start is low
      while (!quiet && $urandom_range(99) < 27) begin
         start      <= 1'b0;
         req_letter <= LETTER_W'($urandom);
         req_last   <= 1'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic add_row(input logic [LETTER_W-1:0] letter, input int reps, input logic last,
                          input logic typed, input rsp_status_type status);
      word_row_type row;
      row.letter = letter;
      row.reps   = 7'(reps);
      row.last   = last;
      row.typed  = typed;
      row.status = status;
      word_table.push_back(row);
   endtask

   // One random word. Flavours: narrow alphabet (lots of repeated letters), full 5-bit
   // range (codes above 25 too), and non-increasing words that have no next permutation.
   task automatic send_word(input int len, input int flavour);
      logic [LETTER_W-1:0] letter;
      logic [LETTER_W-1:0] cur;
      int                  top;
      int                  k;
      top = $urandom_range(1, 3);
      cur = LETTER_W'($urandom_range(31));
      for (k = 0; k < len; k++) begin
         case (flavour)
            0: begin
               letter = LETTER_W'($urandom_range(top));
            end
            1: begin
               letter = LETTER_W'($urandom_range(31));
            end
            default: begin
               letter = cur;
               cur    = cur - ((cur < 2) ? cur : LETTER_W'($urandom_range(0, 2)));
            end
         endcase
         send_beat(letter, k == len - 1, 1'b0, RSP_LETTER);
      end
   endtask

   // Result side: the block cannot be stalled, so every strobe is checked at once
   always @(posedge clock) begin
      perm_beat_type exp_beat;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: letter %0d status %0d last %0b",
                                      rsp_out_letter, rsp_status, rsp_out_last));
         end else begin
            exp_beat = awaited_results.pop_front();
            if (rsp_out_letter !== exp_beat.letter || rsp_status !== exp_beat.status ||
                rsp_out_last !== exp_beat.last)
               report_mismatch($sformatf({"result: got letter %0d status %0d last %0b, ",
                                          "expected letter %0d status %0d last %0b"},
                                         rsp_out_letter, rsp_status, rsp_out_last,
                                         exp_beat.letter, exp_beat.status, exp_beat.last));
         end
      end
   end

   initial begin : stimulus
      int          len;
      int          pick;
      int          flavour;
      int          row;
      int          rep;
      int          random_start;

      // Directed words. Single-letter, over-long and most non-increasing words have an outcome
      // that needs no working out, so it is typed in; the rest go to the predictor.
      add_row(5'd0,  1,  1'b1, 1'b1, RSP_NONE);   // "a" straight after reset
      add_row(5'd25, 1,  1'b1, 1'b1, RSP_NONE);   // "z"
      add_row(5'd0,  1,  1'b0, 1'b0, RSP_LETTER); // "ab" -> "ba"
      add_row(5'd1,  1,  1'b1, 1'b0, RSP_LETTER);
      add_row(5'd1,  1,  1'b0, 1'b0, RSP_LETTER); // "ba": already last
      add_row(5'd0,  1,  1'b1, 1'b1, RSP_NONE);
      add_row(5'd0,  1,  1'b0, 1'b0, RSP_LETTER); // code 31 compared as a plain value
      add_row(5'd31, 1,  1'b1, 1'b0, RSP_LETTER);
      add_row(5'd31, 1,  1'b0, 1'b0, RSP_LETTER); // descending with codes above 25
      add_row(5'd30, 1,  1'b0, 1'b0, RSP_LETTER);
      add_row(5'd16, 1,  1'b1, 1'b1, RSP_NONE);
      add_row(5'd3,  1,  1'b0, 1'b0, RSP_LETTER); // "dcab" -> "dcba"
      add_row(5'd2,  1,  1'b0, 1'b0, RSP_LETTER);
      add_row(5'd0,  1,  1'b0, 1'b0, RSP_LETTER);
      add_row(5'd1,  1,  1'b1, 1'b0, RSP_LETTER);
      add_row(5'd0,  1,  1'b0, 1'b0, RSP_LETTER); // "abb" -> "bab": equal letters
      add_row(5'd1,  2,  1'b1, 1'b0, RSP_LETTER);
      add_row(5'd0,  63, 1'b0, 1'b0, RSP_LETTER); // exactly full store, pivot at the end
      add_row(5'd1,  1,  1'b1, 1'b0, RSP_LETTER);
      add_row(5'd1,  1,  1'b0, 1'b0, RSP_LETTER); // full store, non-increasing: no next permutation
      add_row(5'd0,  63, 1'b1, 1'b0, RSP_LETTER);
      add_row(5'd25, 64, 1'b1, 1'b1, RSP_NONE);   // full store of 'z'
      add_row(5'd7,  65, 1'b1, 1'b1, RSP_LONG);   // one letter too many
      add_row(5'd12, 69, 1'b0, 1'b0, RSP_LETTER); // well over, last beat dropped too
      add_row(5'd3,  1,  1'b1, 1'b1, RSP_LONG);
      add_row(5'd2,  1,  1'b1, 1'b1, RSP_NONE);   // overflow flag must not linger

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < word_table.size(); row++) begin
         for (rep = 0; rep < word_table[row].reps; rep++) begin
            if (rep == word_table[row].reps - 1)
               send_beat(word_table[row].letter, word_table[row].last,
                         word_table[row].typed, word_table[row].status);
            else
               send_beat(word_table[row].letter, 1'b0, 1'b0, RSP_LETTER);
         end
      end

      // Random words: mostly short, a few long, a few over the limit
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         // a long stretch with the sender never idling
         quiet = (beats_sent - random_start >= 20) && (beats_sent - random_start < 90);
         pick  = $urandom_range(99);
         if (pick < 70)      len = $urandom_range(1, 8);
         else if (pick < 90) len = $urandom_range(9, 20);
         else if (pick < 96) len = $urandom_range(21, WORD_MAX);
         else                len = $urandom_range(WORD_MAX + 1, WORD_MAX + 6);
         pick = $urandom_range(99);
         flavour = (pick < 45) ? 0 : (pick < 85) ? 1 : 2;
         send_word(len, flavour);
      end
      start <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      // anything further would be a spurious result
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("TIMEOUT: %0d results still awaited", awaited_results.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
